// ===== sv/rfd_pkg.sv =====
// Shared types and constants for the refraction direction pipeline.
`default_nettype none

package rfd_pkg;

    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int ETA_W     = 16;
    localparam int ETA_FRAC  = 12;

    // Square root of (1.0 - sin2_t) scaled by 2^FRAC_BITS gives at most FRAC_BITS + 1 bits.
    localparam int ROOT_W    = FRAC_BITS + 1;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int SQ_STEP   = 4;
    localparam int SQ_STAGES = (ROOT_W + SQ_STEP - 1) / SQ_STEP;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t             dir_x;
        comp_t             dir_y;
        comp_t             dir_z;
        comp_t             nrm_x;
        comp_t             nrm_y;
        comp_t             nrm_z;
        logic [ETA_W-1:0]  eta_ratio;
    } rfd_in_t;

    typedef struct packed {
        logic  refracted_ok;
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
    } rfd_out_t;

endpackage

`default_nettype wire

// ===== sv/rfd_sqrt.sv =====
// Pipelined integer square root, a few result bits per register stage.
`default_nettype none

module rfd_sqrt
    import rfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [SQ_STAGES-1:0] ld,
    input  wire logic [RAD_W-1:0]     rad,
    output logic      [ROOT_W-1:0]    root
);

    logic [REM_W-1:0]  rem_reg  [SQ_STAGES-1];
    logic [RAD_W-1:0]  rad_reg  [SQ_STAGES-1];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_in;
        logic [RAD_W-1:0]  rad_next;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // Restoring square root: bring down two radicand bits, try (4*root + 1).
        always_comb
        begin
            logic [REM_W-1:0] trial;
            trial     = '0;
            rem_next  = rem_in;
            root_next = root_in;
            rad_next  = rad_in;
            for (int j = 0; j < SQ_STEP; j++)
            begin
                if (SQ_STEP * s + j < ROOT_W)
                begin
                    rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
                    rad_next = {rad_next[RAD_W-3:0], 2'b00};
                    trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_next, 2'b01};
                    if (rem_next >= trial)
                    begin
                        rem_next  = rem_next - trial;
                        root_next = {root_next[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        root_next = {root_next[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[s])
            begin
                root_reg[s] <= root_next;
            end
        end

        if (s < SQ_STAGES - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ld[s])
                begin
                    rem_reg[s] <= rem_next;
                    rad_reg[s] <= rad_next;
                end
            end
        end
        else begin : g_last
            logic unused_tail;
            assign unused_tail = ^{rem_next, rad_next};
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/refraction_direction.sv =====
// Refraction of a direction vector about a surface normal by Snell's law.
// An accepted input transaction is registered through every pipeline stage in turn before its result is on out_data.
// Throughput is one transaction per cycle while out_stall is low; every stage holds its own valid bit and a
// stalled output only holds the stages that are full, so bubbles are squeezed out.
// The 15-bit square root takes four of those stages, up to four result bits per stage.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module refraction_direction
    import rfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire rfd_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output rfd_out_t      out_data
);

    localparam int DEPTH  = 13;
    localparam int SQ_LO  = 7;
    localparam int SQ_HI  = SQ_LO + SQ_STAGES - 1;
    localparam int DN_W   = 2 * COMP_W - FRAC_BITS;             // floor(d*n / 2^14)
    localparam int SUM_W  = DN_W + 1;
    localparam int NED_W  = ETA_W + COMP_W - ETA_FRAC + 1;      // floor(eta*(-d) / 2^12)
    localparam int SIN_W  = FRAC_BITS + 1;
    localparam int EE_W   = 2 * ETA_W;
    localparam int PRD_W  = EE_W + SIN_W;
    localparam int K_W    = NED_W + 1;
    localparam int KN_W   = K_W + COMP_W - FRAC_BITS;
    localparam int OSUM_W = KN_W + 1;
    localparam int TIR_LSB = 2 * ETA_FRAC + FRAC_BITS;

    localparam logic [SIN_W-1:0] ONE = SIN_W'(1) << FRAC_BITS;
    localparam comp_t COMP_HI = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t COMP_LO = {1'b1, {(COMP_W-1){1'b0}}};

    typedef struct packed {
        logic                   tir;
        logic [NED_W-1:0]       ecos;
        logic [2:0][NED_W-1:0]  ned;
        logic [2:0][COMP_W-1:0] nrm;
    } side_t;

    logic [DEPTH:1] v_reg;
    logic [DEPTH:1] rdy;

    // Stage 1
    logic signed [DN_W-1:0]   dn1_reg   [3];
    logic signed [NED_W-1:0]  ned1_reg  [3];
    comp_t                    nrm1_reg  [3];
    logic [EE_W-1:0]          ee1_reg;
    logic [ETA_W-1:0]         eta1_reg;
    // Stage 2
    comp_t                    cos2_reg;
    logic signed [NED_W-1:0]  ned2_reg  [3];
    comp_t                    nrm2_reg  [3];
    logic [EE_W-1:0]          ee2_reg;
    logic [ETA_W-1:0]         eta2_reg;
    // Stage 3
    logic                     big3_reg;
    logic [FRAC_BITS-1:0]     cc3_reg;
    logic signed [NED_W-1:0]  ecos3_reg;
    logic signed [NED_W-1:0]  ned3_reg  [3];
    comp_t                    nrm3_reg  [3];
    logic [EE_W-1:0]          ee3_reg;
    // Stage 4
    logic [SIN_W-1:0]         sin4_reg;
    logic signed [NED_W-1:0]  ecos4_reg;
    logic signed [NED_W-1:0]  ned4_reg  [3];
    comp_t                    nrm4_reg  [3];
    logic [EE_W-1:0]          ee4_reg;
    // Stage 5
    logic [PRD_W-1:0]         prd5_reg;
    logic signed [NED_W-1:0]  ecos5_reg;
    logic signed [NED_W-1:0]  ned5_reg  [3];
    comp_t                    nrm5_reg  [3];
    // Stages 6 to 10
    logic [RAD_W-1:0]         rad6_reg;
    side_t                    side_reg  [SQ_LO-1:SQ_HI];
    logic [ROOT_W-1:0]        root;
    // Stage 11
    logic signed [K_W-1:0]    k11_reg;
    logic signed [NED_W-1:0]  ned11_reg [3];
    comp_t                    nrm11_reg [3];
    logic                     tir11_reg;
    // Stage 12
    logic signed [KN_W-1:0]   kn12_reg  [3];
    logic signed [NED_W-1:0]  ned12_reg [3];
    logic                     tir12_reg;
    // Stage 13
    rfd_out_t                 out_reg;

    comp_t dir_in [3];
    comp_t nrm_in [3];

    assign dir_in[0] = in_data.dir_x;
    assign dir_in[1] = in_data.dir_y;
    assign dir_in[2] = in_data.dir_z;
    assign nrm_in[0] = in_data.nrm_x;
    assign nrm_in[1] = in_data.nrm_y;
    assign nrm_in[2] = in_data.nrm_z;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        rdy[DEPTH] = !v_reg[DEPTH] || !out_stall;
        for (int i = DEPTH - 1; i >= 1; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[1];
    assign out_valid = v_reg[DEPTH];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int i = 2; i <= DEPTH; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: per-axis products d*n and eta*(-d), and eta squared.
    logic signed [2*COMP_W-1:0]       dn_p   [3];
    logic signed [COMP_W:0]           negd   [3];
    logic signed [ETA_W+COMP_W+1:0]   ned_p  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dn_p[i]  = dir_in[i] * nrm_in[i];
            negd[i]  = -{dir_in[i][COMP_W-1], dir_in[i]};
            ned_p[i] = $signed({1'b0, in_data.eta_ratio}) * negd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dn1_reg[i]  <= dn_p[i][2*COMP_W-1:FRAC_BITS];
                ned1_reg[i] <= ned_p[i][ETA_FRAC+NED_W-1:ETA_FRAC];
                nrm1_reg[i] <= nrm_in[i];
            end
            ee1_reg  <= in_data.eta_ratio * in_data.eta_ratio;
            eta1_reg <= in_data.eta_ratio;
        end
    end

    // Stage 2: cos_i as the saturated dot product.
    logic signed [SUM_W-1:0] cos_sum;

    assign cos_sum = SUM_W'(dn1_reg[0]) + SUM_W'(dn1_reg[1]) + SUM_W'(dn1_reg[2]);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            if (&cos_sum[SUM_W-1:COMP_W-1] || ~|cos_sum[SUM_W-1:COMP_W-1])
            begin
                cos2_reg <= cos_sum[COMP_W-1:0];
            end
            else
            begin
                cos2_reg <= cos_sum[SUM_W-1] ? COMP_LO : COMP_HI;
            end
            ned2_reg <= ned1_reg;
            nrm2_reg <= nrm1_reg;
            ee2_reg  <= ee1_reg;
            eta2_reg <= eta1_reg;
        end
    end

    // Stage 3: cos_i squared and eta*cos_i.
    logic signed [2*COMP_W-1:0]     cc_p;
    logic signed [ETA_W+COMP_W:0]   ecos_p;
    logic                           big;

    assign cc_p   = cos2_reg * cos2_reg;
    assign ecos_p = $signed({1'b0, eta2_reg}) * cos2_reg;
    assign big    = (cos2_reg >= $signed(COMP_W'(ONE))) || (cos2_reg <= -$signed(COMP_W'(ONE)));

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            big3_reg  <= big;
            cc3_reg   <= cc_p[2*FRAC_BITS-1:FRAC_BITS];
            ecos3_reg <= ecos_p[ETA_FRAC+NED_W-1:ETA_FRAC];
            ned3_reg  <= ned2_reg;
            nrm3_reg  <= nrm2_reg;
            ee3_reg   <= ee2_reg;
        end
    end

    // Stage 4: sin2_i, clamped at zero once |cos_i| reaches 1.0.
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            sin4_reg  <= big3_reg ? '0 : ONE - {1'b0, cc3_reg};
            ecos4_reg <= ecos3_reg;
            ned4_reg  <= ned3_reg;
            nrm4_reg  <= nrm3_reg;
            ee4_reg   <= ee3_reg;
        end
    end

    // Stage 5: eta^2 * sin2_i, still at full precision.
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            prd5_reg  <= PRD_W'(ee4_reg * sin4_reg);
            ecos5_reg <= ecos4_reg;
            ned5_reg  <= ned4_reg;
            nrm5_reg  <= nrm4_reg;
        end
    end

    // Stage 6: exact reflection test and the radicand (1.0 - sin2_t) << 14.
    logic [FRAC_BITS-1:0] sin2_t;

    assign sin2_t = prd5_reg[TIR_LSB-1:2*ETA_FRAC];

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            side_reg[SQ_LO-1].tir  <= |prd5_reg[PRD_W-1:TIR_LSB];
            side_reg[SQ_LO-1].ecos <= ecos5_reg;
            for (int i = 0; i < 3; i++)
            begin
                side_reg[SQ_LO-1].ned[i] <= ned5_reg[i];
                side_reg[SQ_LO-1].nrm[i] <= nrm5_reg[i];
            end
            rad6_reg <= RAD_W'({ONE - {1'b0, sin2_t}, {FRAC_BITS{1'b0}}});
        end
    end

    // Stages 7 to 10: cos_t by square root; side data travels alongside.
    rfd_sqrt u_sqrt (
        .clk  (clk),
        .ld   (rdy[SQ_HI:SQ_LO]),
        .rad  (rad6_reg),
        .root (root)
    );

    for (genvar g = SQ_LO; g <= SQ_HI; g++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (rdy[g])
            begin
                side_reg[g] <= side_reg[g-1];
            end
        end
    end

    // Stage 11: k = eta*cos_i - cos_t.
    always_ff @(posedge clk)
    begin
        if (rdy[11])
        begin
            k11_reg <= K_W'($signed(side_reg[SQ_HI].ecos)) - $signed(K_W'(root));
            for (int i = 0; i < 3; i++)
            begin
                ned11_reg[i] <= side_reg[SQ_HI].ned[i];
                nrm11_reg[i] <= side_reg[SQ_HI].nrm[i];
            end
            tir11_reg <= side_reg[SQ_HI].tir;
        end
    end

    // Stage 12: k*n per axis.
    logic signed [K_W+COMP_W-1:0] kn_p [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kn_p[i] = k11_reg * nrm11_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[12])
        begin
            for (int i = 0; i < 3; i++)
            begin
                kn12_reg[i] <= kn_p[i][K_W+COMP_W-1:FRAC_BITS];
            end
            ned12_reg <= ned11_reg;
            tir12_reg <= tir11_reg;
        end
    end

    // Stage 13: sum, saturate, and zero the vector on total internal reflection.
    logic signed [OSUM_W-1:0] osum [3];
    comp_t                    osat [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            osum[i] = OSUM_W'(ned12_reg[i]) + OSUM_W'(kn12_reg[i]);
            if (&osum[i][OSUM_W-1:COMP_W-1] || ~|osum[i][OSUM_W-1:COMP_W-1])
            begin
                osat[i] = osum[i][COMP_W-1:0];
            end
            else
            begin
                osat[i] = osum[i][OSUM_W-1] ? COMP_LO : COMP_HI;
            end
            if (tir12_reg)
            begin
                osat[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[13])
        begin
            out_reg.refracted_ok <= !tir12_reg;
            out_reg.out_x        <= osat[0];
            out_reg.out_y        <= osat[1];
            out_reg.out_z        <= osat[2];
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_refraction_direction.sv =====
// Self-checking testbench for the refraction direction pipeline.
module tb_refraction_direction
    import rfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PER_PHASE = 450;
    localparam int NUM_CASES      = 14;

    localparam comp_t P1 = 16'sd16384;
    localparam comp_t M1 = -16'sd16384;
    localparam comp_t D45 = 16'sd11585;

    typedef struct packed {
        rfd_in_t  ray;
        logic     typed;
        rfd_out_t want;
    } ray_case_t;

    // Rows with typed set carry a result worked out by hand; the rest use the predictor.
    localparam ray_case_t RAY_CASES [NUM_CASES] = '{
        // Head-on through a unit index: the ray goes straight on.
        '{'{16'sd0, 16'sd0, M1, 16'sd0, 16'sd0, P1, 16'd4096}, 1'b1,
          '{1'b1, 16'sd0, 16'sd0, M1}},
        // Zero index: only the normal term survives.
        '{'{P1, 16'sd0, 16'sd0, 16'sd0, P1, 16'sd0, 16'd0}, 1'b1,
          '{1'b1, 16'sd0, M1, 16'sd0}},
        // Grazing with index 2.0 is total internal reflection.
        '{'{P1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, P1, 16'd8192}, 1'b1,
          '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
        // Grazing with index 1.0 lands exactly on the reflection threshold.
        '{'{P1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, P1, 16'd4096}, 1'b1,
          '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
        // Zero vectors with index 1.0 also sit on the threshold.
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd4096}, 1'b1,
          '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
        // One LSB below the threshold refracts to a zero vector.
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd4095}, 1'b1,
          '{1'b1, 16'sd0, 16'sd0, 16'sd0}},
        // The cosine saturates, and a zero index leaves only the normal term.
        '{'{M1, M1, M1, M1, M1, M1, 16'd0}, 1'b1,
          '{1'b1, P1, P1, P1}},
        '{'{16'sd0, 16'sd0, M1, 16'sd0, 16'sd0, P1, 16'hFFFF}, 1'b0, '0},
        '{'{M1, M1, M1, P1, P1, P1, 16'hFFFF}, 1'b0, '0},
        '{'{P1, P1, P1, P1, P1, P1, 16'hFFFF}, 1'b0, '0},
        '{'{D45, 16'sd0, -D45, 16'sd0, 16'sd0, P1, 16'd6144}, 1'b0, '0},
        '{'{D45, 16'sd0, D45, 16'sd0, 16'sd0, P1, 16'd6144}, 1'b0, '0},
        '{'{P1, M1, 16'sd0, M1, 16'sd0, P1, 16'hFFFF}, 1'b0, '0},
        '{'{16'sd0, D45, -D45, 16'sd0, 16'sd0, P1, 16'd1}, 1'b0, '0}
    };

    localparam int GAP_PCT [3]   = '{38, 78, 0};
    localparam int STALL_PCT [3] = '{78, 38, 0};

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    rfd_in_t  in_data;
    logic     out_valid;
    logic     out_stall = 1'b0;
    rfd_out_t out_data;

    rfd_out_t refracted_q [$];
    int       err_cnt = 0;
    int       idle_cycles = 0;
    int       src_gap_pct = 0;
    int       sink_stall_pct = 0;

    refraction_direction DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic comp_t clamp_comp(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COMP_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return comp_t'(v);
    endfunction

    // Fixed-point Snell refraction; every scaled product rounds toward minus infinity.
    function automatic rfd_out_t refract_ray(rfd_in_t r);
        longint   one;
        longint   dv [3];
        longint   nv [3];
        longint   eta;
        longint   cos_i;
        longint   sin2_i;
        longint   prod;
        longint   rad;
        longint   root;
        longint   trial;
        longint   k;
        int       i;
        int       b;
        rfd_out_t res;
        one = longint'(1) <<< FRAC_BITS;
        dv[0] = r.dir_x;
        dv[1] = r.dir_y;
        dv[2] = r.dir_z;
        nv[0] = r.nrm_x;
        nv[1] = r.nrm_y;
        nv[2] = r.nrm_z;
        eta = longint'(r.eta_ratio);
        cos_i = 0;
        for (i = 0; i < 3; i++)
            cos_i += (dv[i] * nv[i]) >>> FRAC_BITS;
        cos_i = clamp_comp(cos_i);
        if (cos_i >= one || cos_i <= -one)
            sin2_i = 0;
        else
            sin2_i = one - ((cos_i * cos_i) >>> FRAC_BITS);
        prod = eta * eta * sin2_i;
        if (prod >= (longint'(1) <<< (2 * ETA_FRAC + FRAC_BITS)))
            return '0;
        rad = (one - (prod >>> (2 * ETA_FRAC))) <<< FRAC_BITS;
        root = 0;
        for (b = ROOT_W; b >= 0; b--)
        begin
            trial = root | (longint'(1) <<< b);
            if (trial * trial <= rad)
                root = trial;
        end
        k = ((eta * cos_i) >>> ETA_FRAC) - root;
        res.refracted_ok = 1'b1;
        res.out_x = clamp_comp(((eta * -dv[0]) >>> ETA_FRAC) + ((k * nv[0]) >>> FRAC_BITS));
        res.out_y = clamp_comp(((eta * -dv[1]) >>> ETA_FRAC) + ((k * nv[1]) >>> FRAC_BITS));
        res.out_z = clamp_comp(((eta * -dv[2]) >>> ETA_FRAC) + ((k * nv[2]) >>> FRAC_BITS));
        return res;
    endfunction

    function automatic void unit_vec(output comp_t x, output comp_t y, output comp_t z);
        int  a;
        int  b;
        int  c;
        real len;
        a = int'($urandom_range(32768)) - 16384;
        b = int'($urandom_range(32768)) - 16384;
        c = int'($urandom_range(32768)) - 16384;
        len = $sqrt(real'(a * a + b * b + c * c));
        if (len < 1.0)
        begin
            x = '0;
            y = '0;
            z = P1;
        end
        else
        begin
            x = comp_t'(int'(16384.0 * a / len));
            y = comp_t'(int'(16384.0 * b / len));
            z = comp_t'(int'(16384.0 * c / len));
        end
    endfunction

    // Mostly unit rays against a facing normal with a plausible index; the rest is raw noise.
    function automatic rfd_in_t make_ray();
        rfd_in_t r;
        comp_t   x;
        comp_t   y;
        comp_t   z;
        longint  dot;
        int      pick;
        if ($urandom_range(99) < 75)
        begin
            unit_vec(x, y, z);
            r.dir_x = x;
            r.dir_y = y;
            r.dir_z = z;
            unit_vec(x, y, z);
            dot = longint'(r.dir_x) * x + longint'(r.dir_y) * y + longint'(r.dir_z) * z;
            if (dot > 0 && $urandom_range(4) != 0)
            begin
                x = -x;
                y = -y;
                z = -z;
            end
            r.nrm_x = x;
            r.nrm_y = y;
            r.nrm_z = z;
            pick = $urandom_range(99);
            if (pick < 55)
                r.eta_ratio = 16'($urandom_range(8192, 2048));
            else if (pick < 80)
                r.eta_ratio = 16'($urandom_range(4400, 3800));
            else
                r.eta_ratio = 16'($urandom_range(65535));
        end
        else
        begin
            r.dir_x = comp_t'(int'($urandom_range(32768)) - 16384);
            r.dir_y = comp_t'(int'($urandom_range(32768)) - 16384);
            r.dir_z = comp_t'(int'($urandom_range(32768)) - 16384);
            r.nrm_x = comp_t'(int'($urandom_range(32768)) - 16384);
            r.nrm_y = comp_t'(int'($urandom_range(32768)) - 16384);
            r.nrm_z = comp_t'(int'($urandom_range(32768)) - 16384);
            r.eta_ratio = 16'($urandom_range(65535));
        end
        return r;
    endfunction

    task automatic send_ray(rfd_in_t ray, logic typed, rfd_out_t want);
        while ($urandom_range(99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ray;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        refracted_q.push_back(typed ? want : refract_ray(ray));
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    initial
    begin
        int phase;
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 3; phase++)
        begin
            src_gap_pct    = GAP_PCT[phase];
            sink_stall_pct = STALL_PCT[phase];
            if (phase == 0)
                for (i = 0; i < NUM_CASES; i++)
                    send_ray(RAY_CASES[i].ray, RAY_CASES[i].typed, RAY_CASES[i].want);
            for (i = 0; i < RANDOM_PER_PHASE; i++)
                send_ray(make_ray(), 1'b0, '0);
            // Hold off the source until the pipeline has fully drained.
            in_valid <= 1'b0;
            while (refracted_q.size() != 0)
                @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        rfd_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (refracted_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %p", $time, out_data);
                err_cnt++;
            end
            else
            begin
                want = refracted_q.pop_front();
                check_field("refracted_ok", want.refracted_ok, out_data.refracted_ok);
                check_field("out_x", want.out_x, out_data.out_x);
                check_field("out_y", want.out_y, out_data.out_y);
                check_field("out_z", want.out_z, out_data.out_z);
            end
        end
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Ends a hung run: counts cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
